// File: rtl/texture_sampler_wrap_bilinear_assert.svh
// assertion macros for the texture sampler rtl
// no dependencies; included by modules that check their own logic
`ifndef TEXTURE_SAMPLER_WRAP_BILINEAR_ASSERT_SVH
`define TEXTURE_SAMPLER_WRAP_BILINEAR_ASSERT_SVH
// same-cycle implication
`define TSW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("texture sampler check failed");
// next-cycle implication
`define TSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("texture sampler check failed");
`endif

// File: rtl/tsw_pkg.sv
// types, constants and helpers for the texture sampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package tsw_pkg;
	localparam int CHANNEL_BITS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int MAX_TEXELS_DEF = 65536;
	localparam int CHAN_W  = 16;
	localparam int COORD_W = 24;
	localparam int DIM_W   = 9;
	localparam int POS_W   = 8;
	localparam int FIX_W   = FRAC_BITS + 1;
	localparam int PROD_W  = FIX_W + DIM_W;
	localparam int FADDR_W = 17;
	localparam int TEXEL_W = 4 * CHAN_W;
	localparam int DIFF_W  = CHAN_W + 1;
	localparam int MUL_W   = DIFF_W + FRAC_BITS + 1;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int ONE_FX  = 1 << FRAC_BITS;
	localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'((1 << CHANNEL_BITS) - 1);

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// wrap modes
	localparam logic [1:0] WRAP_BORDER = 2'd0;
	localparam logic [1:0] WRAP_CLAMP  = 2'd1;
	localparam logic [1:0] WRAP_REPEAT = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_TEX_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_TEX_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_FILTER     = 3'd2;
	localparam logic [2:0] CFG_WRAP       = 3'd3;
	localparam logic [2:0] CFG_BORDER     = 3'd4;

	typedef struct packed {
		logic                      operation;
		logic [15:0]               texel_index;
		logic [CHAN_W-1:0]         in_red;
		logic [CHAN_W-1:0]         in_green;
		logic [CHAN_W-1:0]         in_blue;
		logic [CHAN_W-1:0]         in_alpha;
		logic signed [COORD_W-1:0] coord_u;
		logic signed [COORD_W-1:0] coord_v;
	} req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
	} res_t;

	// effective configuration seen by the datapath
	typedef struct packed {
		logic [DIM_W-1:0]   tex_w;
		logic [DIM_W-1:0]   tex_h;
		logic               filter;
		logic [1:0]         wrap;
		logic [TEXEL_W-1:0] border;
	} cfg_t;

	// one queued operation between front and back
	typedef struct packed {
		logic                 is_write;
		logic [15:0]          waddr;
		logic [TEXEL_W-1:0]   wdata;
		logic                 border;
		logic [FADDR_W-1:0]   a00;
		logic [FADDR_W-1:0]   a01;
		logic [FADDR_W-1:0]   a10;
		logic [FADDR_W-1:0]   a11;
		logic [FRAC_BITS-1:0] fu;
		logic [FRAC_BITS-1:0] fv;
	} qent_t;

	// size register to texel count: zero acts as one, large values as 256
	function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (r > DIM_W'(256)) begin
			d = DIM_W'(256);
		end else begin
			d = r;
		end
		return d;
	endfunction
endpackage

// File: rtl/texture_sampler_wrap_bilinear.sv
// texture sampler: one request per cycle unless stalled, nearest or bilinear, with wrap modes
// registers in order: front request, position, queue slot, fetch, u products, rows, v products, output
// throughput: one request per cycle while nothing stalls; four texels come from two dual-read store copies
// writes travel through the same queue, so a sample sees every earlier write
// reset clears control and the configuration registers; the texel store is not cleared
// depends on tsw_pkg, tsw_front, tsw_queue and tsw_back
`timescale 1ns / 1ps
module texture_sampler_wrap_bilinear import tsw_pkg::*; #(
	parameter int MAX_TEXELS = MAX_TEXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [TEXEL_W-1:0] cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res
);
	logic [DIM_W-1:0]   tex_width_q;
	logic [DIM_W-1:0]   tex_height_q;
	logic               filter_q;
	logic [1:0]         wrap_q;
	logic [TEXEL_W-1:0] border_q;
	cfg_t               cfg;
	logic               push, full, pop, empty;
	qent_t              push_entry, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= DIM_W'(256);
			tex_height_q <= DIM_W'(256);
			filter_q     <= 1'b0;
			wrap_q       <= WRAP_CLAMP;
			border_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEX_WIDTH:  tex_width_q  <= cfg_data[DIM_W-1:0];
				CFG_TEX_HEIGHT: tex_height_q <= cfg_data[DIM_W-1:0];
				CFG_FILTER:     filter_q     <= cfg_data[0];
				CFG_WRAP:       wrap_q       <= cfg_data[1:0];
				CFG_BORDER:     border_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes
	always_comb begin
		cfg.tex_w  = dim_of(tex_width_q);
		cfg.tex_h  = dim_of(tex_height_q);
		cfg.filter = filter_q;
		cfg.wrap   = wrap_q;
		cfg.border = border_q;
	end

	tsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req_valid  (req_valid),
		.req        (req),
		.req_stall  (req_stall),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	tsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	tsw_back #(
		.MAX_TEXELS (MAX_TEXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.border_rgba (cfg.border),
		.q_valid     (!empty),
		.q_head      (head),
		.pop         (pop),
		.res_valid   (res_valid),
		.res         (res),
		.res_stall   (res_stall)
	);
endmodule

// File: rtl/tsw_queue.sv
// short fifo between the sampler front end and the texel back end
// depends on tsw_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "texture_sampler_wrap_bilinear_assert.svh"
module tsw_queue import tsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_entry,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output qent_t head
);
	qent_t              slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`TSW_ASSERT_IMPL(a_push_not_full, clk, arst_n, push, !full)
	`TSW_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, pop, !empty)
	`TSW_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`TSW_ASSERT_NEXT(a_cnt_down, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
endmodule

// File: rtl/tsw_front.sv
// front end: takes requests, applies wrap, finds texel addresses and weights
// depends on tsw_pkg; feeds tsw_queue
`timescale 1ns / 1ps
module tsw_front import tsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  req_valid,
	input  req_t  req,
	output logic  req_stall,
	output logic  push,
	output qent_t push_entry,
	input  logic  full
);
	logic                 v_s1;
	req_t                 req_s1;
	logic                 v_s2;
	logic                 write_s2;
	logic [15:0]          waddr_s2;
	logic [TEXEL_W-1:0]   wdata_s2;
	logic                 border_s2;
	logic [POS_W-1:0]     x_s2;
	logic [POS_W-1:0]     y_s2;
	logic [FRAC_BITS-1:0] fu_s2;
	logic [FRAC_BITS-1:0] fv_s2;

	logic ld_s2;
	logic ld_s1;

	logic             hit_u, hit_v, border_hit;
	logic [FIX_W-1:0] u_w, v_w;
	logic [DIM_W-1:0] mul_w, mul_h, wm1, hm1;
	logic [PROD_W-1:0] pu, pv;
	logic [DIM_W:0]   qu, qv;
	logic [POS_W-1:0] x_c, y_c;
	logic             edge_hit;
	logic             no_filter;
	logic [FADDR_W-1:0] base;

	// handshake chain
	assign push      = v_s2 && !full;
	assign ld_s2     = !v_s2 || !full;
	assign ld_s1     = !v_s1 || ld_s2;
	assign req_stall = !ld_s1;

	// wrap of both coordinates
	always_comb begin
		hit_u = (req_s1.coord_u < 0) || (req_s1.coord_u > $signed(COORD_W'(ONE_FX)));
		hit_v = (req_s1.coord_v < 0) || (req_s1.coord_v > $signed(COORD_W'(ONE_FX)));
		border_hit = 1'b0;
		case (cfg.wrap)
			WRAP_BORDER: begin
				u_w = req_s1.coord_u[FIX_W-1:0];
				v_w = req_s1.coord_v[FIX_W-1:0];
				border_hit = hit_u || hit_v;
			end
			WRAP_REPEAT: begin
				u_w = {1'b0, req_s1.coord_u[FRAC_BITS-1:0]};
				v_w = {1'b0, req_s1.coord_v[FRAC_BITS-1:0]};
			end
			default: begin
				if (req_s1.coord_u < 0) begin
					u_w = '0;
				end else if (hit_u) begin
					u_w = FIX_W'(ONE_FX);
				end else begin
					u_w = req_s1.coord_u[FIX_W-1:0];
				end
				if (req_s1.coord_v < 0) begin
					v_w = '0;
				end else if (hit_v) begin
					v_w = FIX_W'(ONE_FX);
				end else begin
					v_w = req_s1.coord_v[FIX_W-1:0];
				end
			end
		endcase
	end

	// scale to texel space: size for nearest, size minus one for bilinear
	always_comb begin
		wm1   = cfg.tex_w - 1'b1;
		hm1   = cfg.tex_h - 1'b1;
		mul_w = cfg.filter ? wm1 : cfg.tex_w;
		mul_h = cfg.filter ? hm1 : cfg.tex_h;
		pu    = PROD_W'(u_w) * PROD_W'(mul_w);
		pv    = PROD_W'(v_w) * PROD_W'(mul_h);
		qu    = pu[FRAC_BITS +: DIM_W+1];
		qv    = pv[FRAC_BITS +: DIM_W+1];
		x_c   = (qu > (DIM_W+1)'(wm1)) ? POS_W'(wm1) : POS_W'(qu);
		y_c   = (qv > (DIM_W+1)'(hm1)) ? POS_W'(hm1) : POS_W'(qv);
		edge_hit  = (DIM_W'(x_c) == wm1) || (DIM_W'(y_c) == hm1);
		no_filter = !cfg.filter || edge_hit || border_hit;
	end

	// stage 1: request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			req_s1 <= req;
		end
	end

	// stage 2: texel position and weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			write_s2  <= (req_s1.operation == OP_WRITE);
			waddr_s2  <= req_s1.texel_index;
			wdata_s2  <= {req_s1.in_red & CHAN_MASK, req_s1.in_green & CHAN_MASK,
				req_s1.in_blue & CHAN_MASK, req_s1.in_alpha & CHAN_MASK};
			border_s2 <= border_hit;
			x_s2      <= x_c;
			y_s2      <= y_c;
			fu_s2     <= no_filter ? '0 : pu[FRAC_BITS-1:0];
			fv_s2     <= no_filter ? '0 : pv[FRAC_BITS-1:0];
		end
	end

	// linear addresses of the four neighbors
	always_comb begin
		base = FADDR_W'(y_s2) * FADDR_W'(cfg.tex_w) + FADDR_W'(x_s2);
		push_entry.is_write = write_s2;
		push_entry.waddr    = waddr_s2;
		push_entry.wdata    = wdata_s2;
		push_entry.border   = border_s2;
		push_entry.a00      = base;
		push_entry.a01      = base + 1'b1;
		push_entry.a10      = base + FADDR_W'(cfg.tex_w);
		push_entry.a11      = base + FADDR_W'(cfg.tex_w) + 1'b1;
		push_entry.fu       = fu_s2;
		push_entry.fv       = fv_s2;
	end
endmodule

// File: rtl/tsw_back.sv
// back end: texel store, four-texel fetch and two-level lerp pipeline
// depends on tsw_pkg; drains tsw_queue
`timescale 1ns / 1ps
module tsw_back import tsw_pkg::*; #(
	parameter int MAX_TEXELS = MAX_TEXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [TEXEL_W-1:0] border_rgba,
	input  logic               q_valid,
	input  qent_t              q_head,
	output logic               pop,
	output logic               res_valid,
	output res_t               res,
	input  logic               res_stall
);
	localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

	typedef logic [3:0][CHAN_W-1:0] texel_t;

	// two copies, each read at two addresses
	logic [TEXEL_W-1:0] mem0 [MAX_TEXELS];
	logic [TEXEL_W-1:0] mem1 [MAX_TEXELS];

	logic                 v_s1, v_s2, v_s3, v_s4;
	texel_t               rd00_s1, rd01_s1, rd10_s1, rd11_s1;
	logic [3:0]           oob_s1;
	logic                 border_s1;
	logic [FRAC_BITS-1:0] fu_s1, fv_s1, fv_s2, fv_s3;
	texel_t               a0_s2, a1_s2;
	logic signed [MUL_W-1:0] p0_s2 [4];
	logic signed [MUL_W-1:0] p1_s2 [4];
	texel_t               r0_s3, r1_s3, r0_s4;
	logic signed [MUL_W-1:0] p_s4 [4];
	logic                 res_valid_q;
	res_t                 res_q;

	logic ld_o, ld4, ld3, ld2, ld1;
	logic wr_ok;
	texel_t t00, t01, t10, t11, row0, row1, fin;
	logic signed [DIFF_W-1:0] d0 [4];
	logic signed [DIFF_W-1:0] d1 [4];
	logic signed [DIFF_W-1:0] d2 [4];
	logic signed [MUL_W-1:0]  m0 [4];
	logic signed [MUL_W-1:0]  m1 [4];
	logic signed [MUL_W-1:0]  m2 [4];

	// stall chain from the result side
	assign ld_o = !res_valid_q || !res_stall;
	assign ld4  = !v_s4 || ld_o;
	assign ld3  = !v_s3 || ld4;
	assign ld2  = !v_s2 || ld3;
	assign ld1  = !v_s1 || ld2;
	assign pop  = q_valid && ld1;
	assign wr_ok = 32'(q_head.waddr) < 32'(MAX_TEXELS);

	// texel writes
	always_ff @(posedge clk) begin
		if (pop && q_head.is_write && wr_ok) begin
			mem0[AW'(q_head.waddr)] <= q_head.wdata;
			mem1[AW'(q_head.waddr)] <= q_head.wdata;
		end
	end

	// stage 1: texel fetch
	always_ff @(posedge clk) begin
		if (ld1) begin
			rd00_s1   <= mem0[AW'(q_head.a00)];
			rd01_s1   <= mem0[AW'(q_head.a01)];
			rd10_s1   <= mem1[AW'(q_head.a10)];
			rd11_s1   <= mem1[AW'(q_head.a11)];
			oob_s1    <= {32'(q_head.a11) >= 32'(MAX_TEXELS),
				32'(q_head.a10) >= 32'(MAX_TEXELS),
				32'(q_head.a01) >= 32'(MAX_TEXELS),
				32'(q_head.a00) >= 32'(MAX_TEXELS)};
			border_s1 <= q_head.border;
			fu_s1     <= q_head.fu;
			fv_s1     <= q_head.fv;
		end
	end

	// border substitution, missing texels read as zero, horizontal products
	// a neighbor with zero weight repeats a used texel so unread entries stay out
	always_comb begin
		t00 = border_s1 ? texel_t'(border_rgba) : (oob_s1[0] ? '0 : rd00_s1);
		t01 = (fu_s1 == '0) ? t00 : ((border_s1 || oob_s1[1]) ? '0 : rd01_s1);
		t10 = (fv_s1 == '0) ? t00 : ((border_s1 || oob_s1[2]) ? '0 : rd10_s1);
		t11 = (fu_s1 == '0) ? t10 :
			((fv_s1 == '0) ? t01 : ((border_s1 || oob_s1[3]) ? '0 : rd11_s1));
		for (int c = 0; c < 4; c++) begin
			d0[c] = $signed({1'b0, t01[c]}) - $signed({1'b0, t00[c]});
			d1[c] = $signed({1'b0, t11[c]}) - $signed({1'b0, t10[c]});
			m0[c] = MUL_W'(d0[c] * $signed({1'b0, fu_s1}));
			m1[c] = MUL_W'(d1[c] * $signed({1'b0, fu_s1}));
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			a0_s2 <= t00;
			a1_s2 <= t10;
			p0_s2 <= m0;
			p1_s2 <= m1;
			fv_s2 <= fv_s1;
		end
	end

	// row results: floored step added modulo channel width
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			row0[c] = a0_s2[c] + p0_s2[c][FRAC_BITS +: CHAN_W];
			row1[c] = a1_s2[c] + p1_s2[c][FRAC_BITS +: CHAN_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			r0_s3 <= row0;
			r1_s3 <= row1;
			fv_s3 <= fv_s2;
		end
	end

	// vertical products
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			d2[c] = $signed({1'b0, r1_s3[c]}) - $signed({1'b0, r0_s3[c]});
			m2[c] = MUL_W'(d2[c] * $signed({1'b0, fv_s3}));
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			r0_s4 <= r0_s3;
			p_s4  <= m2;
		end
	end

	// final colour
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			fin[c] = r0_s4[c] + p_s4[c][FRAC_BITS +: CHAN_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_o) begin
			res_q <= res_t'(fin);
		end
	end

	// valid bits of the back pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= pop && !q_head.is_write;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
			if (ld_o) begin
				res_valid_q <= v_s4;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

// File: test/texture_sampler_wrap_bilinear_checker.sv
// checker for the texture sampler: watches config writes and both channels
// keeps its own texel store and config copy, predicts each sample and compares
// depends on tsw_pkg
`timescale 1ns / 1ps
module texture_sampler_wrap_bilinear_checker import tsw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [TEXEL_W-1:0] cfg_data,
	input  logic               req_valid,
	input  logic               req_stall,
	input  req_t               req,
	input  logic               res_valid,
	input  logic               res_stall,
	input  res_t               res,
	output int                 failures,
	output int                 pending
);
	logic [63:0] texels [int];
	logic [8:0]  width_reg, height_reg;
	logic        bilinear_reg;
	logic [1:0]  wrap_reg;
	logic [63:0] border_reg;
	res_t        colors_due [$];

	function automatic longint eff_dim(input logic [8:0] r);
		if (r == 0) return 1;
		if (r > 256) return 256;
		return r;
	endfunction

	function automatic logic [63:0] fetch(input longint a);
		if (a >= 65536 || !texels.exists(int'(a))) return 64'd0;
		return texels[int'(a)];
	endfunction

	// wrap one coordinate; returns 0 on a border hit
	function automatic bit wrap_coord(input logic signed [23:0] c, output longint r);
		longint cv;
		cv = c;
		r = 0;
		if (wrap_reg == WRAP_BORDER) begin
			if (cv < 0 || cv > 65536) return 0;
			r = cv;
		end else if (wrap_reg == WRAP_REPEAT) begin
			r = cv & 64'hFFFF;
		end else begin
			r = cv < 0 ? 0 : (cv > 65536 ? 65536 : cv);
		end
		return 1;
	endfunction

	// floored lerp per channel
	function automatic logic [63:0] blend(input logic [63:0] a, input logic [63:0] b,
			input longint f);
		logic [63:0] r;
		longint d, ca, cb;
		r = 0;
		for (int k = 0; k < 4; k++) begin
			ca = a[16*k +: 16];
			cb = b[16*k +: 16];
			d = (cb - ca) * f;
			r[16*k +: 16] = 16'(ca + (d >>> 16));
		end
		return r;
	endfunction

	function automatic res_t sample_color(input logic signed [23:0] cu,
			input logic signed [23:0] cv);
		longint w, h, u, v, x, y, pu, pv, base;
		logic [63:0] t, row0, row1;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		if (!wrap_coord(cu, u) || !wrap_coord(cv, v)) begin
			t = border_reg;
		end else if (!bilinear_reg) begin
			x = (u * w) >> 16;
			y = (v * h) >> 16;
			if (x > w - 1) x = w - 1;
			if (y > h - 1) y = h - 1;
			t = fetch(y * w + x);
		end else begin
			pu = u * (w - 1);
			pv = v * (h - 1);
			x = pu >> 16;
			y = pv >> 16;
			base = y * w + x;
			if (x == w - 1 || y == h - 1) begin
				t = fetch(base);
			end else begin
				row0 = blend(fetch(base), fetch(base + 1), pu & 64'hFFFF);
				row1 = blend(fetch(base + w), fetch(base + w + 1), pu & 64'hFFFF);
				t = blend(row0, row1, pv & 64'hFFFF);
			end
		end
		return res_t'(t);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			width_reg <= 9'd256;
			height_reg <= 9'd256;
			bilinear_reg <= 1'b0;
			wrap_reg <= WRAP_CLAMP;
			border_reg <= '0;
			failures <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_TEX_WIDTH:  width_reg <= cfg_data[8:0];
					CFG_TEX_HEIGHT: height_reg <= cfg_data[8:0];
					CFG_FILTER:     bilinear_reg <= cfg_data[0];
					CFG_WRAP:       wrap_reg <= cfg_data[1:0];
					CFG_BORDER:     border_reg <= cfg_data;
					default: ;
				endcase
			end
			// compare result with oldest expected color
			if (res_valid && !res_stall) begin
				if (colors_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res);
					failures <= failures + 1;
				end else begin
					want = colors_due.pop_front();
					if (want.out_red !== res.out_red || want.out_green !== res.out_green ||
							want.out_blue !== res.out_blue ||
							want.out_alpha !== res.out_alpha) begin
						$display("%0t: color mismatch expected %h actual %h", $time, want,
							res);
						failures <= failures + 1;
					end
				end
			end
			// accepted request
			if (req_valid && !req_stall) begin
				if (req.operation == OP_WRITE) begin
					texels[int'(req.texel_index)] = {req.in_red, req.in_green, req.in_blue,
						req.in_alpha};
				end else begin
					colors_due.push_back(sample_color(req.coord_u, req.coord_v));
				end
			end
			pending <= colors_due.size();
		end
	end
endmodule

// File: test/texture_sampler_wrap_bilinear_test.sv
// testbench top for the texture sampler: reset, config phases, request stimulus
// makes sure every texel a sample touches was written first; verdict from the checker
// depends on tsw_pkg, texture_sampler_wrap_bilinear and its checker
`timescale 1ns / 1ps
module texture_sampler_wrap_bilinear_test;
	import tsw_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [TEXEL_W-1:0] cfg_data;
	logic               req_valid;
	logic               req_stall;
	req_t               req;
	logic               res_valid;
	logic               res_stall;
	res_t               res;
	int                 failures;
	int                 pending;

	bit          written [65536];
	logic [8:0]  cur_w, cur_h;
	logic        cur_bilinear;
	logic [1:0]  cur_wrap;
	int          requests_sent;
	int          idle_mode;
	int          quiet_cycles;

	texture_sampler_wrap_bilinear uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	texture_sampler_wrap_bilinear_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stall pattern
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= (idle_mode == 0) ? ($urandom_range(0, 99) < 60) :
				(idle_mode == 1) ? ($urandom_range(0, 99) < 8) : 1'b0;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 3000) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int dim_val(input logic [8:0] r);
		if (r == 0) return 1;
		if (r > 256) return 256;
		return r;
	endfunction

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 11))
			0: return 24'($urandom);
			1: return 24'sd0;
			2: return 24'sd65536;
			3: return 24'sd65535;
			4: return 24'sd65537;
			5: return -24'sd1;
			6: return 24'($urandom_range(0, 8 * 65536)) - 24'sd262144;
			default: return 24'($urandom_range(0, 98304)) - 24'sd16384;
		endcase
	endfunction

	// texel addresses a sample reads under the current settings
	task automatic sample_taps(input logic signed [23:0] cu, input logic signed [23:0] cv,
			output int taps [$]);
		longint c [2];
		longint p [2];
		longint w, h, x, y;
		bit hit;
		taps.delete();
		w = dim_val(cur_w);
		h = dim_val(cur_h);
		c[0] = cu;
		c[1] = cv;
		hit = 0;
		for (int i = 0; i < 2; i++) begin
			if (cur_wrap == WRAP_BORDER) begin
				if (c[i] < 0 || c[i] > 65536) hit = 1;
			end else if (cur_wrap == WRAP_REPEAT) begin
				c[i] = c[i] & 64'hFFFF;
			end else begin
				c[i] = c[i] < 0 ? 0 : (c[i] > 65536 ? 65536 : c[i]);
			end
		end
		if (hit) return;
		if (!cur_bilinear) begin
			x = (c[0] * w) >> 16;
			y = (c[1] * h) >> 16;
			if (x > w - 1) x = w - 1;
			if (y > h - 1) y = h - 1;
			taps.push_back(int'(y * w + x));
		end else begin
			p[0] = c[0] * (w - 1);
			p[1] = c[1] * (h - 1);
			x = p[0] >> 16;
			y = p[1] >> 16;
			taps.push_back(int'(y * w + x));
			if (x != w - 1 && y != h - 1) begin
				taps.push_back(int'(y * w + x + 1));
				taps.push_back(int'(y * w + x + w));
				taps.push_back(int'(y * w + x + w + 1));
			end
		end
	endtask

	// drive one request and hold it until accepted
	task automatic send(input req_t item);
		if (idle_mode != 2) begin
			while ($urandom_range(0, 99) < (idle_mode == 0 ? 8 : 60)) begin
				req_valid = 1'b0;
				@(negedge clk);
			end
		end
		req = item;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		req_valid = 1'b0;
		requests_sent++;
		idle_mode = requests_sent < 550 ? 0 : (requests_sent < 1100 ? 1 : 2);
	endtask

	task automatic write_texel(input int addr);
		req_t item;
		item = req_t'({$urandom, $urandom, $urandom, $urandom});
		item.operation = OP_WRITE;
		item.texel_index = 16'(addr);
		item.in_red = rand_chan();
		item.in_green = rand_chan();
		item.in_blue = rand_chan();
		item.in_alpha = rand_chan();
		written[addr] = 1'b1;
		send(item);
	endtask

	// writes whatever texels are still blank, then the sample itself
	task automatic sample_at(input logic signed [23:0] cu, input logic signed [23:0] cv);
		int taps [$];
		req_t item;
		sample_taps(cu, cv, taps);
		foreach (taps[i]) if (!written[taps[i]]) write_texel(taps[i]);
		item = req_t'({$urandom, $urandom, $urandom, $urandom});
		item.operation = OP_SAMPLE;
		item.coord_u = cu;
		item.coord_v = cv;
		send(item);
	endtask

	// register write once the pipe has drained
	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_mode(input logic [8:0] w, input logic [8:0] h, input logic bl,
			input logic [1:0] wr, input logic [63:0] brd);
		cfg_write(CFG_TEX_WIDTH, 64'(w));
		cfg_write(CFG_TEX_HEIGHT, 64'(h));
		cfg_write(CFG_FILTER, 64'(bl));
		cfg_write(CFG_WRAP, 64'(wr));
		cfg_write(CFG_BORDER, brd);
		cur_w = w;
		cur_h = h;
		cur_bilinear = bl;
		cur_wrap = wr;
	endtask

	initial begin
		logic [8:0] mode_w [10] = '{8, 1, 0, 256, 16, 300, 256, 1, 12, 511};
		logic [8:0] mode_h [10] = '{8, 1, 5, 256, 3, 2, 256, 256, 9, 7};
		logic       mode_bl [10] = '{1, 1, 0, 0, 1, 1, 1, 0, 1, 1};
		logic [1:0] mode_wr [10] = '{1, 2, 0, 1, 2, 3, 0, 2, 0, 1};
		int total;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		requests_sent = 0;
		idle_mode = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: 4x4 bilinear border, edges, corners, extremes
		set_mode(9'd4, 9'd4, 1'b1, WRAP_BORDER, 64'hFFFF_0000_FFFF_0000);
		for (int i = 0; i < 16; i++) write_texel(i);
		sample_at(24'sd0, 24'sd0);
		sample_at(24'sd65536, 24'sd65536);
		sample_at(24'sd32768, 24'sd21845);
		sample_at(-24'sd1, 24'sd100);
		sample_at(24'sd65537, 24'sd0);
		sample_at(24'sh7FFFFF, 24'sh800000);
		sample_at(24'sd65535, 24'sd1);

		// random phases over several settings
		for (int m = 0; m < 10; m++) begin
			set_mode(mode_w[m], mode_h[m], mode_bl[m], mode_wr[m],
				{$urandom, $urandom} | (m == 6 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0));
			total = dim_val(mode_w[m]) * dim_val(mode_h[m]);
			if (total <= 64) for (int i = 0; i < total; i++) write_texel(i);
			for (int k = 0; k < 110; k++) begin
				if ($urandom_range(0, 9) < 2) begin
					write_texel($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) :
						$urandom_range(0, total - 1));
				end else begin
					sample_at(rand_coord(), rand_coord());
				end
			end
		end

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
